/* src/mpb_pkg.sv */
`default_nettype none

package mpb_pkg;

    // operation codes of an input item
    localparam logic [2:0] MODE_WRITE = 3'd0;
    localparam logic [2:0] MODE_READ  = 3'd1;
    localparam logic [2:0] MODE_TICK  = 3'd2;
    localparam logic [2:0] MODE_PAD   = 3'd3;
    localparam logic [2:0] MODE_POWER = 3'd4;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_TOTAL_SONGS   = 3'd0,
        REG_STARTING_SONG = 3'd1,
        REG_INITIAL_BANKS = 3'd2,
        REG_BANK_MASK     = 3'd3,
        REG_LOAD_ADDRESS  = 3'd4,
        REG_DISK_MODE     = 3'd5,
        REG_VIDEO_PAL     = 3'd6
    } cfg_reg_t;

    // decoded bus addresses
    localparam logic [15:0] ADDR_CTRL_LO   = 16'h3FF0;
    localparam logic [15:0] ADDR_RELOAD    = 16'h3FF0;
    localparam logic [15:0] ADDR_SONG      = 16'h3FF1;
    localparam logic [15:0] ADDR_NMI_ON    = 16'h3FF3;
    localparam logic [15:0] ADDR_NMI_OFF   = 16'h3FF4;
    localparam logic [15:0] ADDR_NMI_ALT   = 16'h3FF5;
    localparam logic [15:0] ADDR_CTRL_HI   = 16'h3FFF;
    localparam logic [15:0] ADDR_BANK_LO   = 16'h5FF6;
    localparam logic [15:0] ADDR_BANK_DISK = 16'h5FF7;
    localparam logic [15:0] ADDR_BANK_HI   = 16'h5FFF;
    localparam logic [15:0] ADDR_VEC_LO    = 16'hFFFA;
    localparam logic [15:0] ADDR_VEC_HI    = 16'hFFFD;

    localparam logic [7:0] RELOAD_SET = 8'hFF;
    localparam logic [7:0] SONG_JUMP  = 8'd10;

    // override vector bytes, indexed by address bits 1..0
    localparam logic [7:0] VECTOR_BYTES [4] = '{8'h00, 8'h38, 8'h20, 8'h38};

    localparam int STEP_W = 4;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  open_bus;
        logic        debug_access;
        logic [4:0]  buttons;
    } item_t;

    typedef struct packed {
        logic       read_valid;
        logic [7:0] read_data;
        logic       pass_through;
        logic       bank_valid;
        logic [3:0] bank_slot;
        logic [7:0] bank_number;
        logic       nmi_request;
        logic       sound_reset;
        logic       last_result;
    } result_t;

    typedef struct packed {
        logic              accept;
        logic              decode;
        logic              load;
        logic [STEP_W-1:0] step;
    } ctl_cmd_t;

    typedef struct packed {
        logic              out_free;
        logic [STEP_W-1:0] last_step;
    } dp_sts_t;

endpackage

`default_nettype wire

/* src/mpb_ctrl.sv */
`default_nettype none

module mpb_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mpb_pkg::dp_sts_t  sts,
    output mpb_pkg::ctl_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EMIT
    } state_t;

    state_t                      state_reg, state_next;
    logic [mpb_pkg::STEP_W-1:0]  step_reg, step_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                step_next  = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load = 1'b1;
                    if (step_reg == sts.last_step)
                        state_next = ST_IDLE;
                    else
                        step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

/* src/mpb_dp.sv */
`default_nettype none

module mpb_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mpb_pkg::item_t    in_data,
    input  wire logic              cfg_valid,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [63:0]       cfg_data,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output mpb_pkg::result_t       out_data,
    input  wire mpb_pkg::ctl_cmd_t cmd,
    output mpb_pkg::dp_sts_t       sts
);

    // shape of the result list of the current item
    typedef enum logic [2:0] {
        PL_SINGLE,
        PL_SONG,
        PL_POWER_BANKS,
        PL_POWER_DISK,
        PL_POWER_LOAD
    } plan_t;

    // configuration
    logic [7:0]  total_songs_reg;
    logic [7:0]  starting_song_reg;
    logic [63:0] initial_banks_reg;
    logic [7:0]  bank_mask_reg;
    logic [15:0] load_address_reg;
    logic        disk_mode_reg;
    logic        video_pal_reg;

    // player state
    logic [7:0] current_song_reg, current_song_next;
    logic       reload_pending_reg, reload_pending_next;
    logic [1:0] nmi_enables_reg, nmi_enables_next;
    logic       vector_override_reg, vector_override_next;
    logic [4:0] previous_buttons_reg, previous_buttons_next;

    // item and plan
    mpb_pkg::item_t             item_reg;
    plan_t                      plan_reg, plan_next;
    logic [mpb_pkg::STEP_W-1:0] last_step_reg, last_step_next;
    mpb_pkg::result_t           first_reg, first_next;
    logic [2:0]                 start_reg, start_next;

    logic             out_valid_reg;
    mpb_pkg::result_t out_data_reg;
    mpb_pkg::result_t res;

    logic       bank_on;
    logic       vec_ovr;
    logic       nmi_live;
    logic [4:0] rise;
    logic [8:0] song_up;
    logic [2:0] res_k;
    logic [3:0] res_slot;
    logic [7:0] res_num;

    function automatic mpb_pkg::result_t bank_res(input logic [3:0] slot,
                                                  input logic [7:0] num);
        mpb_pkg::result_t r;
        r             = '0;
        r.bank_valid  = 1'b1;
        r.bank_slot   = slot;
        r.bank_number = num;
        return r;
    endfunction

    assign bank_on  = (initial_banks_reg != 64'd0);
    assign nmi_live = (nmi_enables_reg[0] && reload_pending_reg) || nmi_enables_reg[1];
    assign vec_ovr  = nmi_live || vector_override_reg;
    assign rise     = item_reg.buttons & ~previous_buttons_reg;
    assign song_up  = {1'b0, current_song_reg} + {1'b0, mpb_pkg::SONG_JUMP};

    // decode of the latched item, committed on cmd.decode
    always_comb
    begin
        current_song_next     = current_song_reg;
        reload_pending_next   = reload_pending_reg;
        nmi_enables_next      = nmi_enables_reg;
        vector_override_next  = vector_override_reg;
        previous_buttons_next = previous_buttons_reg;
        plan_next             = PL_SINGLE;
        last_step_next        = '0;
        first_next            = '0;
        start_next            = load_address_reg[14:12];
        case (item_reg.mode)
            mpb_pkg::MODE_WRITE:
            begin
                if (item_reg.address == mpb_pkg::ADDR_NMI_ON)
                    nmi_enables_next[0] = 1'b1;
                else if (item_reg.address == mpb_pkg::ADDR_NMI_OFF)
                    nmi_enables_next[1] = 1'b0;
                else if (item_reg.address == mpb_pkg::ADDR_NMI_ALT)
                    nmi_enables_next[1] = 1'b1;
                else if (item_reg.address >= mpb_pkg::ADDR_BANK_LO
                         && item_reg.address <= mpb_pkg::ADDR_BANK_HI)
                begin
                    if (!((item_reg.address <= mpb_pkg::ADDR_BANK_DISK && !disk_mode_reg)
                          || !bank_on))
                        first_next = bank_res(item_reg.address[3:0],
                                              item_reg.write_data & bank_mask_reg);
                end
            end
            mpb_pkg::MODE_READ:
            begin
                if (item_reg.address >= mpb_pkg::ADDR_CTRL_LO
                    && item_reg.address <= mpb_pkg::ADDR_CTRL_HI)
                begin
                    first_next.read_valid = 1'b1;
                    if (item_reg.address == mpb_pkg::ADDR_RELOAD)
                    begin
                        first_next.read_data = reload_pending_reg ? mpb_pkg::RELOAD_SET : 8'd0;
                        if (!item_reg.debug_access)
                            reload_pending_next = 1'b0;
                    end
                    else if (item_reg.address == mpb_pkg::ADDR_SONG)
                    begin
                        first_next.read_data   = current_song_reg - 8'd1;
                        first_next.sound_reset = !item_reg.debug_access;
                        if (!item_reg.debug_access && bank_on)
                        begin
                            plan_next      = PL_SONG;
                            last_step_next = 4'd8;
                        end
                    end
                    else if (item_reg.address == mpb_pkg::ADDR_NMI_ON)
                        first_next.read_data = {7'd0, video_pal_reg};
                end
                else if (item_reg.address >= mpb_pkg::ADDR_VEC_LO
                         && item_reg.address <= mpb_pkg::ADDR_VEC_HI)
                begin
                    if (vec_ovr)
                    begin
                        first_next.read_valid = 1'b1;
                        first_next.read_data  = mpb_pkg::VECTOR_BYTES[item_reg.address[1:0]];
                        if (item_reg.address == mpb_pkg::ADDR_VEC_HI && !item_reg.debug_access)
                            vector_override_next = 1'b0;
                    end
                    else
                        first_next.pass_through = 1'b1;
                end
            end
            mpb_pkg::MODE_TICK:
            begin
                first_next.nmi_request = nmi_live;
            end
            mpb_pkg::MODE_PAD:
            begin
                if (rise[0])
                begin
                    if (current_song_reg < total_songs_reg)
                    begin
                        current_song_next   = current_song_reg + 8'd1;
                        reload_pending_next = 1'b1;
                    end
                end
                else if (rise[1])
                begin
                    if (current_song_reg > 8'd1)
                    begin
                        current_song_next   = current_song_reg - 8'd1;
                        reload_pending_next = 1'b1;
                    end
                end
                else if (rise[2])
                begin
                    current_song_next   = (song_up > {1'b0, total_songs_reg})
                                          ? total_songs_reg : song_up[7:0];
                    reload_pending_next = 1'b1;
                end
                else if (rise[3])
                begin
                    current_song_next   = (current_song_reg < mpb_pkg::SONG_JUMP + 8'd1)
                                          ? 8'd1 : current_song_reg - mpb_pkg::SONG_JUMP;
                    reload_pending_next = 1'b1;
                end
                else if (rise[4])
                    reload_pending_next = 1'b1;
                previous_buttons_next = item_reg.buttons;
            end
            mpb_pkg::MODE_POWER:
            begin
                vector_override_next = 1'b1;
                current_song_next    = starting_song_reg;
                reload_pending_next  = 1'b1;
                nmi_enables_next     = 2'd0;
                if (bank_on && disk_mode_reg)
                begin
                    plan_next      = PL_POWER_DISK;
                    last_step_next = 4'd9;
                end
                else if (bank_on)
                begin
                    plan_next      = PL_POWER_BANKS;
                    last_step_next = 4'd7;
                end
                else
                begin
                    plan_next      = PL_POWER_LOAD;
                    last_step_next = {1'b0, 3'd7 - load_address_reg[14:12]};
                end
            end
            default:
            begin
                first_next = '0;
            end
        endcase
    end

    // result of the current step
    always_comb
    begin
        res_k    = cmd.step[2:0];
        res_slot = {1'b1, cmd.step[2:0]};
        case (plan_reg)
            PL_SONG:
            begin
                res_k    = cmd.step[2:0] - 3'd1;
                res_slot = {1'b1, res_k};
            end
            PL_POWER_DISK:
            begin
                case (cmd.step)
                    4'd6:    begin res_k = 3'd6; res_slot = 4'd6;  end
                    4'd7:    begin res_k = 3'd6; res_slot = 4'd14; end
                    4'd8:    begin res_k = 3'd7; res_slot = 4'd7;  end
                    4'd9:    begin res_k = 3'd7; res_slot = 4'd15; end
                    default: begin res_k = cmd.step[2:0]; res_slot = {1'b1, cmd.step[2:0]}; end
                endcase
            end
            PL_POWER_LOAD:
            begin
                res_k    = start_reg + cmd.step[2:0];
                res_slot = {1'b1, res_k};
            end
            default:
            begin
                res_k    = cmd.step[2:0];
                res_slot = {1'b1, cmd.step[2:0]};
            end
        endcase
        if (plan_reg == PL_POWER_LOAD)
            res_num = {5'd0, cmd.step[2:0]} & bank_mask_reg;
        else
            res_num = initial_banks_reg[res_k*8 +: 8] & bank_mask_reg;
        if (plan_reg == PL_SINGLE || (plan_reg == PL_SONG && cmd.step == '0))
            res = first_reg;
        else
            res = bank_res(res_slot, res_num);
        res.last_result = (cmd.step == last_step_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_songs_reg      <= 8'd1;
            starting_song_reg    <= 8'd1;
            initial_banks_reg    <= 64'd0;
            bank_mask_reg        <= 8'd0;
            load_address_reg     <= 16'h8000;
            disk_mode_reg        <= 1'b0;
            video_pal_reg        <= 1'b0;
            current_song_reg     <= 8'd1;
            reload_pending_reg   <= 1'b1;
            nmi_enables_reg      <= 2'd0;
            vector_override_reg  <= 1'b1;
            previous_buttons_reg <= 5'd0;
            plan_reg             <= PL_SINGLE;
            last_step_reg        <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (mpb_pkg::cfg_reg_t'(cfg_index))
                    mpb_pkg::REG_TOTAL_SONGS:   total_songs_reg   <= cfg_data[7:0];
                    mpb_pkg::REG_STARTING_SONG: starting_song_reg <= cfg_data[7:0];
                    mpb_pkg::REG_INITIAL_BANKS: initial_banks_reg <= cfg_data;
                    mpb_pkg::REG_BANK_MASK:     bank_mask_reg     <= cfg_data[7:0];
                    mpb_pkg::REG_LOAD_ADDRESS:  load_address_reg  <= cfg_data[15:0];
                    mpb_pkg::REG_DISK_MODE:     disk_mode_reg     <= cfg_data[0];
                    mpb_pkg::REG_VIDEO_PAL:     video_pal_reg     <= cfg_data[0];
                    default:                    video_pal_reg     <= video_pal_reg;
                endcase
            end
            if (cmd.decode)
            begin
                current_song_reg     <= current_song_next;
                reload_pending_reg   <= reload_pending_next;
                nmi_enables_reg      <= nmi_enables_next;
                vector_override_reg  <= vector_override_next;
                previous_buttons_reg <= previous_buttons_next;
                plan_reg             <= plan_next;
                last_step_reg        <= last_step_next;
            end
            if (cmd.load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            item_reg <= in_data;
        if (cmd.decode)
        begin
            first_reg <= first_next;
            start_reg <= start_next;
        end
        if (cmd.load)
            out_data_reg <= res;
    end

    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;
    assign sts.last_step = last_step_reg;

endmodule

`default_nettype wire

/* src/music_player_bank_and_nmi_registers.sv */
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_data   (mpb_pkg::item_t)
// out       output     out_valid / out_ready  out_data  (mpb_pkg::result_t)
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// an item is latched and decoded, and then its results (1 to 10 of them) are put out
// by the result sequencer, one result a cycle while the out channel is not stalled;
// the next item is accepted only after the last result of an item has been loaded
// reset clears config to its defaults and the player state to power-on values
// a stalled out channel holds the output register and pauses the sequencer
// cfg is always ready; each write is registered straight into its config register
`default_nettype none

module music_player_bank_and_nmi_registers (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire mpb_pkg::item_t   in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output mpb_pkg::result_t      out_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [63:0]      cfg_data
);

    // command and status between sequencer and datapath
    mpb_pkg::ctl_cmd_t cmd;
    mpb_pkg::dp_sts_t  sts;

    // config writes never stall
    assign cfg_ready = 1'b1;

    // sequencer: latch, decode, then step through the result list
    mpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: config registers, player state, decode and output register
    mpb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

`ifndef SYNTHESIS
    // one item in flight: accepting an item closes the input
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input reopened right after an item was taken");

    // the output register is only loaded when it is free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> sts.out_free)
        else $error("output register overwritten");

    // a bank result never carries read data or pass-through, and its slot is at least 6
    a_bank_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.bank_valid) |->
        (!out_data.read_valid && !out_data.pass_through && out_data.bank_slot >= 4'd6))
        else $error("malformed bank result");

    // input stays closed until the last result of an item is loaded
    a_last_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(in_ready) && $past(cmd.load)) |-> out_data.last_result)
        else $error("input reopened before the last result");
`endif

endmodule

`default_nettype wire
